// ----- rtl/core/modbus_rtu_response_receiver_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Modbus RTU response receiver
// Concurrent checks clocked on clk, held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define MBRX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true.
`define MBRX_NEVER(name, expr, msg) \
  `MBRX_ASSERT(name, !(expr), msg)

`else

`define MBRX_ASSERT(name, prop, msg)
`define MBRX_NEVER(name, expr, msg)

`endif

`endif

// ----- rtl/core/mbrx_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrx_pkg
// Shared constants, codes and the CRC-16/MODBUS byte update.
// ---------------------------------------------------------------------------
package mbrx_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_DATA_BYTES = 2'd1;

  localparam logic [GAP_W-1:0]  GAP_TIMEOUT_RST    = 16'd20;
  localparam logic [BYTE_W-1:0] ACK_DATA_BYTES_RST = 8'd56;

  // Function codes accepted in a response
  localparam logic [BYTE_W-1:0] FC_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [BYTE_W-1:0] FC_WRITE_MULTI  = 8'h10;

  // Reported frame kinds
  localparam logic [KIND_W-1:0] KIND_READ      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WR_MULTI  = 2'd2;

  localparam logic [BYTE_W-1:0] WRITE_ECHO_BYTES = 8'd4;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;  // reflected 0x8005

  // One byte through the reflected CRC, LSB first
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mbrx_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrx_in_if
// Received byte channel: byte plus tick timestamp, valid/ready.
// ---------------------------------------------------------------------------
interface mbrx_in_if import mbrx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic [TICK_W-1:0] now_ticks;

  modport source (output valid, output rx_byte, output now_ticks, input ready);
  modport sink   (input valid, input rx_byte, input now_ticks, output ready);
endinterface

// ----- rtl/core/mbrx_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrx_out_if
// Frame byte channel: accepted byte, position and frame status, valid/ready.
// ---------------------------------------------------------------------------
interface mbrx_out_if import mbrx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [BYTE_W-1:0] byte_index;
  logic [KIND_W-1:0] func_kind;
  logic              last_of_frame;
  logic              crc_ok;

  modport source (output valid, output frame_byte, output byte_index,
                  output func_kind, output last_of_frame, output crc_ok,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input func_kind, input last_of_frame, input crc_ok,
                  output ready);
endinterface

// ----- rtl/core/modbus_rtu_response_receiver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_rtu_response_receiver
// Frames Modbus RTU responses byte by byte and checks the CRC-16/MODBUS.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    rx_byte[7:0], now_ticks[31:0]
//  out_ch   out  valid/ready    frame_byte, byte_index, func_kind,
//                               last_of_frame, crc_ok
//  cfg_*    in   cfg_we only    cfg_index[1:0], cfg_wdata[15:0]
//
//  One byte per cycle sustained while out_ch does not stall: input register, one
//  pass of framing logic and a byte-wide CRC update, then the result register.
//  A byte taken on in_ch passes the input register and then the result register
//  before it can transfer on out_ch.
//  Reset (synchronous, rst_n low) clears both stages and the framing state;
//  registers return to gap_timeout 20, ack_data_bytes 56.
//  A stall on out_ch holds the result register and then the input register;
//  in_ch.ready drops only when both are full and out_ch.ready is low.
// ---------------------------------------------------------------------------
`include "modbus_rtu_response_receiver_macros.svh"

module modbus_rtu_response_receiver
  import mbrx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mbrx_in_if.sink               in_ch,
  mbrx_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Receive phase; the two unused codes fall back to waiting for an address
  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_READ  = 3'd2,
    PH_CRCL  = 3'd3,
    PH_CRCH  = 3'd4,
    PH_WRITE = 3'd5
  } phase_t;

  // Configuration registers
  logic [GAP_W-1:0]  gap_timeout_r;
  logic [BYTE_W-1:0] ack_data_bytes_r;

  // Input register stage
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [TICK_W-1:0] s1_ticks_r;
  logic              s1_adv;
  logic              s1_fire;

  // Framing state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic [TICK_W-1:0] last_time_r;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] crc_low_r, crc_low_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;

  // Per-byte decisions
  logic [TICK_W-1:0] elapsed;
  logic              timeout;
  phase_t            eff_phase;
  logic [BYTE_W-1:0] base_pos;
  logic [CRC_W-1:0]  crc_step;
  logic              produce;
  logic              last_flag;
  logic              ok_flag;
  logic [KIND_W-1:0] kind_out;

  // Result register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0] out_index_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;
  logic              out_ok_r;

  // Configuration writes; indexes off the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_timeout_r    <= GAP_TIMEOUT_RST;
      ack_data_bytes_r <= ACK_DATA_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAP_TIMEOUT:    gap_timeout_r    <= cfg_wdata;
        REG_ACK_DATA_BYTES: ack_data_bytes_r <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or
  // being drained in this cycle.
  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.rx_byte;
      s1_ticks_r <= in_ch.now_ticks;
    end
  end

  // Gap since the last byte taken into a frame, modulo 2^32
  assign elapsed   = s1_ticks_r - last_time_r;
  assign timeout   = elapsed > {{(TICK_W-GAP_W){1'b0}}, gap_timeout_r};
  assign eff_phase = timeout ? PH_ADDR : phase_r;
  // an address byte always sits at position 0
  assign base_pos  = (eff_phase == PH_ADDR) ? '0 : pos_r;
  assign crc_step  = crc16_update((eff_phase == PH_ADDR) ? CRC_INIT : crc_r, s1_byte_r);

  always_comb begin
    phase_nxt   = eff_phase;
    pos_nxt     = base_pos;
    left_nxt    = left_r;
    crc_nxt     = crc_r;
    crc_low_nxt = crc_low_r;
    kind_nxt    = kind_r;
    produce     = 1'b1;
    last_flag   = 1'b0;
    ok_flag     = 1'b0;
    kind_out    = kind_r;

    unique case (eff_phase)
      PH_ADDR: begin
        if (s1_byte_r == '0) begin
          // broadcast / idle byte: not a response address
          produce = 1'b0;
        end else begin
          crc_nxt   = crc_step;
          kind_nxt  = KIND_READ;
          kind_out  = KIND_READ;
          phase_nxt = PH_FUNC;
        end
      end
      PH_FUNC: begin
        crc_nxt = crc_step;
        if (s1_byte_r == FC_READ_HOLDING) begin
          kind_nxt  = KIND_READ;
          left_nxt  = ack_data_bytes_r;
          phase_nxt = PH_READ;
        end else if (s1_byte_r == FC_WRITE_SINGLE || s1_byte_r == FC_WRITE_MULTI) begin
          kind_nxt  = (s1_byte_r == FC_WRITE_SINGLE) ? KIND_WR_SINGLE : KIND_WR_MULTI;
          left_nxt  = WRITE_ECHO_BYTES;
          phase_nxt = PH_WRITE;
        end else begin
          // unsupported code: dropped, still waiting for a function byte
          produce = 1'b0;
          crc_nxt = crc_r;
        end
        kind_out = kind_nxt;
      end
      PH_READ: begin
        // byte count plus data: one more byte than the register says
        if (left_r == '0) begin
          phase_nxt = PH_CRCL;
        end else begin
          left_nxt = left_r - 1'b1;
        end
        crc_nxt = crc_step;
      end
      PH_WRITE: begin
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          phase_nxt = PH_CRCL;
        end
        crc_nxt = crc_step;
      end
      PH_CRCL: begin
        crc_low_nxt = s1_byte_r;
        phase_nxt   = PH_CRCH;
      end
      PH_CRCH: begin
        last_flag = 1'b1;
        ok_flag   = (crc_low_r == crc_r[7:0]) && (s1_byte_r == crc_r[15:8]);
        phase_nxt = PH_ADDR;
      end
      default: begin
        phase_nxt = PH_ADDR;
        produce   = 1'b0;
      end
    endcase

    if (produce) begin
      pos_nxt = base_pos + 1'b1;
    end
  end

  // Framing state advances once per byte leaving the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADDR;
      pos_r       <= '0;
      left_r      <= '0;
      last_time_r <= '0;
      crc_r       <= CRC_INIT;
      crc_low_r   <= '0;
      kind_r      <= KIND_READ;
    end else if (s1_fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      left_r    <= left_nxt;
      crc_r     <= crc_nxt;
      crc_low_r <= crc_low_nxt;
      kind_r    <= kind_nxt;
      if (produce) begin
        last_time_r <= s1_ticks_r;
      end
    end
  end

  // Result register: loaded when the input stage fires, cleared on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= produce;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      out_byte_r  <= s1_byte_r;
      out_index_r <= base_pos;
      out_kind_r  <= kind_out;
      out_last_r  <= last_flag;
      out_ok_r    <= ok_flag;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_byte    = out_byte_r;
  assign out_ch.byte_index    = out_index_r;
  assign out_ch.func_kind     = out_kind_r;
  assign out_ch.last_of_frame = out_last_r;
  assign out_ch.crc_ok        = out_ok_r;

  // A CRC verdict only ever rides on the closing byte
  `MBRX_NEVER(a_ok_only_on_last, out_ch.valid && out_ch.crc_ok && !out_ch.last_of_frame, "crc_ok without last_of_frame")
  // Reported kind is always a defined one
  `MBRX_NEVER(a_kind_defined, out_ch.valid && (out_ch.func_kind != KIND_READ) && (out_ch.func_kind != KIND_WR_SINGLE) && (out_ch.func_kind != KIND_WR_MULTI), "undefined func_kind")
  // The address byte (and any wrapped read index) carries the read kind
  `MBRX_NEVER(a_index0_kind, out_ch.valid && (out_ch.byte_index == '0) && (out_ch.func_kind != KIND_READ), "index 0 with write kind")
  // After the CRC high byte the receiver waits for a new address
  `MBRX_ASSERT(a_crch_to_addr, s1_fire && (eff_phase == PH_CRCH) |=> (phase_r == PH_ADDR), "phase not back to address")
  // A held input stage keeps its byte
  `MBRX_ASSERT(a_s1_hold, s1_valid_r && !s1_adv |=> s1_valid_r, "input stage lost a byte")

endmodule
